[hdl/kqsb_pkg.sv]
// Shared types, constants and helpers for the shared-buffer queue block.
package kqsb_pkg;

  localparam int unsigned NUM_SLOTS_DEF  = 16;
  localparam int unsigned NUM_QUEUES_DEF = 4;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned QID_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ENQ,
    S_DEQ_RD,
    S_DEQ
  } state_e;

  typedef struct packed {
    logic capture;
    logic rd_queue;
    logic rd_link;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_deq;
    logic head_empty;
  } sts_t;

  // reduce a queue number modulo the queue count
  function automatic logic [QID_W-1:0] qmod(input logic [QID_W-1:0] q, input int unsigned n);
    logic [31:0] r;
    r = 32'(q);
    for (int i = 0; i < 3; i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r[QID_W-1:0];
  endfunction

endpackage

[hdl/k_queues_shared_buffer.sv]
// Top level of the shared-buffer queue block: several FIFO queues in one linked slot store.
// Steps: capture the transaction, read the queue tables and free-list link, then commit an
// enqueue or underflow result; a successful dequeue reads the link and slot stores first.
// A commit waits until the previous result is taken; a new transaction waits for idle.
// Reset: all queues empty and the free list holds every slot in order; a fill count
// stands in for the initial link chain, so no clearing pass runs.
module k_queues_shared_buffer
  import kqsb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int unsigned NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [QID_W-1:0]          queue_id_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] data_out_o,
  output logic [STATUS_W-1:0]       status_o
);

  cmd_t               cmd;
  sts_t               sts;
  logic [VALUE_W-1:0] data_out;

  kqsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kqsb_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kind_i     (kind_i),
    .queue_id_i (queue_id_i),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .data_out_o (data_out),
    .status_o   (status_o)
  );

  assign data_out_o = $signed(data_out);

endmodule

[hdl/kqsb_ctrl.sv]
// Sequencer for the shared-buffer queue block.
module kqsb_ctrl
  import kqsb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_queue = 1'b1;
        state_d        = sts_i.is_deq ? S_DEQ_RD : S_ENQ;
      end
      S_ENQ: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DEQ_RD: begin
        if (sts_i.head_empty) begin
          if (out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.rd_link = 1'b1;
          state_d       = S_DEQ;
        end
      end
      S_DEQ: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/kqsb_datapath.sv]
// Slot store, link store, queue head/tail tables, free list and result register.
module kqsb_datapath
  import kqsb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int unsigned NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      kind_i,
  input  logic [QID_W-1:0]          queue_id_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  output logic [VALUE_W-1:0]        data_out_o,
  output logic [STATUS_W-1:0]       status_o
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned LINK_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);

  function automatic logic [LINK_W-1:0] clean(input logic [LINK_W-1:0] p);
    return (p < NIL) ? p : NIL;
  endfunction

  logic [LINK_W-1:0]     head_mem [NUM_QUEUES];
  logic [LINK_W-1:0]     tail_mem [NUM_QUEUES];
  logic [LINK_W-1:0]     link_mem [NUM_SLOTS];
  logic [DATA_WIDTH-1:0] data_mem [NUM_SLOTS];

  logic                  kind_q;
  logic [QIDX_W-1:0]     qid_q;
  logic [VALUE_W-1:0]    value_q;
  logic [LINK_W-1:0]     free_head_q, free_head_d;
  logic [LINK_W-1:0]     fill_q, fill_d;
  logic [NUM_QUEUES-1:0] head_vld_q;

  logic [LINK_W-1:0]     head_rd_q, tail_rd_q, link_rd_q, link_next_q;
  logic                  head_vld_rd_q, link_fresh_q;
  logic [DATA_WIDTH-1:0] data_rd_q;

  logic [VALUE_W-1:0]    data_out_q;
  status_e               status_q;

  logic [8:0]            qid_full;
  logic [63:0]           val_ext;
  logic [63:0]           rd_ext;
  logic [LINK_W-1:0]     head_cur, tail_cur, link_val, link_addr;
  logic                  head_empty;
  logic                  link_re;

  logic                  head_we, tail_we, link_we, data_we;
  logic [LINK_W-1:0]     head_wdata, link_wdata;
  logic [SLOT_W-1:0]     link_waddr;

  assign qid_full = 9'(qmod(queue_id_i, NUM_QUEUES));
  assign val_ext  = {32'b0, value_q};
  assign rd_ext   = 64'(data_rd_q);

  assign head_cur   = head_vld_rd_q ? clean(head_rd_q) : NIL;
  assign head_empty = (head_cur == NIL);
  assign tail_cur   = clean(tail_rd_q);
  assign link_val   = clean(link_fresh_q ? link_next_q : link_rd_q);
  assign link_addr  = cmd_i.rd_queue ? free_head_q : head_cur;
  assign link_re    = cmd_i.rd_queue || cmd_i.rd_link;

  assign sts_o.is_deq     = kind_q;
  assign sts_o.head_empty = head_empty;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      qid_q   <= qid_full[QIDX_W-1:0];
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_queue) begin
      head_rd_q     <= head_mem[qid_q];
      tail_rd_q     <= tail_mem[qid_q];
      head_vld_rd_q <= head_vld_q[qid_q];
    end
    if (link_re) begin
      link_rd_q    <= link_mem[link_addr[SLOT_W-1:0]];
      link_fresh_q <= (link_addr >= fill_q);
      link_next_q  <= link_addr + LINK_W'(1);
    end
    if (cmd_i.rd_link) begin
      data_rd_q <= data_mem[head_cur[SLOT_W-1:0]];
    end
  end

  always_comb begin
    head_we     = 1'b0;
    tail_we     = 1'b0;
    link_we     = 1'b0;
    data_we     = 1'b0;
    head_wdata  = free_head_q;
    link_wdata  = free_head_q;
    link_waddr  = tail_cur[SLOT_W-1:0];
    free_head_d = free_head_q;
    fill_d      = fill_q;
    if (cmd_i.commit) begin
      if (!kind_q) begin
        if (free_head_q != NIL) begin
          data_we     = 1'b1;
          tail_we     = 1'b1;
          free_head_d = link_val;
          if (free_head_q >= fill_q) begin
            fill_d = fill_q + LINK_W'(1);
          end
          if (head_empty) begin
            head_we    = 1'b1;
            head_wdata = free_head_q;
          end else if (tail_cur != NIL) begin
            link_we    = 1'b1;
            link_waddr = tail_cur[SLOT_W-1:0];
            link_wdata = free_head_q;
          end
        end
      end else if (!head_empty) begin
        head_we     = 1'b1;
        head_wdata  = (head_cur == tail_cur) ? NIL : link_val;
        link_we     = 1'b1;
        link_waddr  = head_cur[SLOT_W-1:0];
        link_wdata  = free_head_q;
        free_head_d = head_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[qid_q] <= head_wdata;
    end
    if (tail_we) begin
      tail_mem[qid_q] <= free_head_q;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (data_we) begin
      data_mem[free_head_q[SLOT_W-1:0]] <= val_ext[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      fill_q      <= '0;
      head_vld_q  <= '0;
    end else begin
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      if (head_we) begin
        head_vld_q[qid_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (!kind_q) begin
        data_out_q <= '0;
        status_q   <= (free_head_q == NIL) ? ST_OVERFLOW : ST_OK;
      end else if (head_empty) begin
        data_out_q <= '0;
        status_q   <= ST_UNDERFLOW;
      end else begin
        data_out_q <= rd_ext[VALUE_W-1:0];
        status_q   <= ST_OK;
      end
    end
  end

  assign data_out_o = data_out_q;
  assign status_o   = status_q;

endmodule
